FILE: rtl/packet_header_deframer_assert.svh
`ifndef PACKET_HEADER_DEFRAMER_ASSERT_SVH
`define PACKET_HEADER_DEFRAMER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PHD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define PHD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/phd_pkg.sv
`timescale 1ns / 1ps

package phd_pkg;

	// largest payload accepted, in bytes
	localparam int unsigned MAX_PAYLOAD = 512;

	// byte counter saturates here
	localparam logic [10:0] POS_MAX = 11'd2047;

	// header sizes for one- and two-byte length encodings
	localparam logic [15:0] HDR_SHORT = 16'd11;
	localparam logic [15:0] HDR_LONG  = 16'd12;

	// offsets back from the header end
	localparam logic [15:0] SEQ_BACK = 16'd9;
	localparam logic [15:0] TS_BACK  = 16'd8;
	localparam logic [15:0] CRC_BYTES = 16'd4;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_NO_HEADER    = 3'd1,
		ST_BAD_TYPE     = 3'd2,
		ST_INCONSISTENT = 3'd3,
		ST_TOO_LONG     = 3'd4
	} status_t;

	// one result item, plus a valid flag
	typedef struct packed {
		logic        valid;
		logic        kind;
		logic [7:0]  payload_byte;
		logic [1:0]  pkt_type;
		logic        truncated_flag;
		logic [4:0]  window;
		logic [14:0] payload_length;
		logic [7:0]  seqnum;
		logic [31:0] timestamp;
		logic [31:0] crc1;
		logic [31:0] crc2;
		status_t     status;
	} res_t;

endpackage

FILE: rtl/phd_parse.sv
`timescale 1ns / 1ps

module phd_parse (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic [7:0]     data_b,
	input  logic           last,
	output phd_pkg::res_t  res
);
	import phd_pkg::*;

	`include "packet_header_deframer_assert.svh"

	logic [10:0] pos_q, pos_d;
	logic        two_q, two_d;
	logic [1:0]  type_q, type_d;
	logic        trunc_q, trunc_d;
	logic [4:0]  win_q, win_d;
	logic [14:0] len_q, len_d;
	logic [7:0]  seq_q, seq_d;
	logic [31:0] ts_q, ts_d;
	logic [31:0] hcrc_q, hcrc_d;
	logic [31:0] pcrc_q, pcrc_d;

	logic [15:0] pos_w, hlen_w, pay_end, crc_end, rel_hdr, rel_pcrc;
	logic [15:0] count_w, hlen_d_w, need_w;
	logic        len_ok, emit;
	status_t     st;

	// position arithmetic against the current header layout
	always_comb begin
		pos_w    = {5'd0, pos_q};
		hlen_w   = two_q ? HDR_LONG : HDR_SHORT;
		pay_end  = hlen_w + {1'b0, len_q};
		crc_end  = pay_end + CRC_BYTES;
		rel_hdr  = pos_w - hlen_w;
		rel_pcrc = pos_w - pay_end;
		len_ok   = (len_q != '0) && ({1'b0, len_q} <= 16'(MAX_PAYLOAD));
	end

	// field capture for the byte at the current position
	always_comb begin
		pos_d   = pos_q;
		two_d   = two_q;
		type_d  = type_q;
		trunc_d = trunc_q;
		win_d   = win_q;
		len_d   = len_q;
		seq_d   = seq_q;
		ts_d    = ts_q;
		hcrc_d  = hcrc_q;
		pcrc_d  = pcrc_q;
		emit    = 1'b0;
		if (pos_q != POS_MAX) begin
			pos_d = pos_q + 11'd1;
			if (pos_w == 16'd0) begin
				type_d  = data_b[7:6];
				trunc_d = data_b[5];
				win_d   = data_b[4:0];
			end else if (pos_w == 16'd1) begin
				two_d = data_b[7];
				len_d = data_b[7] ? {data_b[6:0], 8'h00} : {7'd0, data_b};
			end else if (pos_w == 16'd2 && two_q) begin
				len_d = len_q | {7'd0, data_b};
			end else if (pos_w == hlen_w - SEQ_BACK) begin
				seq_d = data_b;
			end else if (pos_w >= hlen_w - TS_BACK && pos_w < hlen_w - CRC_BYTES) begin
				ts_d[{rel_hdr[1:0], 3'b000} +: 8] = data_b;
			end else if (pos_w >= hlen_w - CRC_BYTES && pos_w < hlen_w) begin
				hcrc_d[{rel_hdr[1:0], 3'b000} +: 8] = data_b;
			end else if (len_ok && pos_w >= hlen_w && pos_w < pay_end) begin
				emit = 1'b1;
			end else if (len_ok && pos_w >= pay_end && pos_w < crc_end) begin
				pcrc_d[{rel_pcrc[1:0], 3'b000} +: 8] = data_b;
			end
		end
	end

	// end of buffer status, checked in priority order
	always_comb begin
		count_w  = pos_w + 16'd1;
		hlen_d_w = two_d ? HDR_LONG : HDR_SHORT;
		need_w   = hlen_d_w + {1'b0, len_d} + CRC_BYTES;
		if (count_w < HDR_SHORT)
			st = ST_NO_HEADER;
		else if (type_d == 2'd0)
			st = ST_BAD_TYPE;
		else if (trunc_d && type_d != 2'd1)
			st = ST_INCONSISTENT;
		else if (two_d && count_w < HDR_LONG)
			st = ST_NO_HEADER;
		else if ({1'b0, len_d} > 16'(MAX_PAYLOAD))
			st = ST_TOO_LONG;
		else if (len_d == '0)
			st = ST_OK;
		else if (count_w < need_w)
			st = ST_INCONSISTENT;
		else
			st = ST_OK;
	end

	// result item: summary on the last byte, otherwise a forwarded payload byte
	always_comb begin
		res                = '0;
		res.valid          = step && (last || emit);
		res.kind           = last;
		res.payload_byte   = last ? 8'h00 : data_b;
		res.status         = ST_OK;
		if (last) begin
			res.pkt_type       = type_d;
			res.truncated_flag = trunc_d;
			res.window         = win_d;
			res.payload_length = len_d;
			res.seqnum         = seq_d;
			res.timestamp      = ts_d;
			res.crc1           = hcrc_d;
			res.crc2           = pcrc_d;
			res.status         = st;
		end
	end

	// parser state, cleared on the last byte of a buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			two_q   <= 1'b0;
			type_q  <= '0;
			trunc_q <= 1'b0;
			win_q   <= '0;
			len_q   <= '0;
			seq_q   <= '0;
			ts_q    <= '0;
			hcrc_q  <= '0;
			pcrc_q  <= '0;
		end else if (step) begin
			if (last) begin
				pos_q   <= '0;
				two_q   <= 1'b0;
				type_q  <= '0;
				trunc_q <= 1'b0;
				win_q   <= '0;
				len_q   <= '0;
				seq_q   <= '0;
				ts_q    <= '0;
				hcrc_q  <= '0;
				pcrc_q  <= '0;
			end else begin
				pos_q   <= pos_d;
				two_q   <= two_d;
				type_q  <= type_d;
				trunc_q <= trunc_d;
				win_q   <= win_d;
				len_q   <= len_d;
				seq_q   <= seq_d;
				ts_q    <= ts_d;
				hcrc_q  <= hcrc_d;
				pcrc_q  <= pcrc_d;
			end
		end
	end

	`PHD_ASSERT_NEXT(a_clear_after_last, step && last, pos_q == '0 && len_q == '0, "state not cleared after last byte")
	`PHD_ASSERT_NEXT(a_pos_advance, step && !last && pos_q != POS_MAX, pos_q == $past(pos_q) + 11'd1, "byte position did not advance")
	`PHD_ASSERT_NOW(a_emit_in_payload, res.valid && !res.kind, !last && len_ok, "payload byte outside a valid payload")
	`PHD_ASSERT_NOW(a_no_result_idle, !step, !res.valid, "result without a byte")

endmodule

FILE: rtl/packet_header_deframer.sv
`timescale 1ns / 1ps

// packet_header_deframer
// Slave side (s_axis_*) takes one buffer byte per item in tdata, with tlast
// on the final byte. Master side (m_axis_*) gives two kinds of result item,
// told apart by tuser: 0 is a forwarded payload byte, 1 is the end of buffer
// summary carrying every header field, both crcs and a status code.
// Payload bytes are forwarded as they arrive; the summary status says
// whether they formed a valid payload.
// A result passes from the input register through the parse stage into the
// output register, from which it leaves.
// Throughput: one byte per cycle while the master side is ready; the byte
// counter, field captures and status compare all fit in the single parse
// stage between the two registers.
// Reset: arst_n clears the parser state and both valid flags; the first byte
// after reset starts a new buffer.
// Stall: while m_axis_tready is low a result holds in the output register,
// the input register keeps one more byte, and s_axis_tready then drops.
module packet_header_deframer (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // data_byte
	input  logic         s_axis_tlast,   // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// payload_byte, pkt_type, truncated_flag, window, payload_length,
	// seqnum, timestamp, crc1, crc2, status, zero fill
	output logic [143:0] m_axis_tdata,
	output logic         m_axis_tuser    // kind
);
	import phd_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       advance;
	logic       out_valid_q;
	res_t       res;
	res_t       out_q;

	// parse stage moves when the output register is free or draining
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	phd_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.data_b (data_s1),
		.last   (last_s1),
		.res    (res)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			out_q <= res;
		end
	end

	// pack the result item, first field lowest
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = {6'd0, out_q.status, out_q.crc2, out_q.crc1, out_q.timestamp,
		out_q.seqnum, out_q.payload_length, out_q.window, out_q.truncated_flag,
		out_q.pkt_type, out_q.payload_byte};

endmodule
